@@ rtl/swdm_pkg.sv @@
// shared types, constants and register codes of the stereo wet/dry mixer
package swdm_pkg;

  localparam int CFG_W           = 24;
  localparam int CFG_IDX_W       = 2;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int GAIN_FRAC_DEF   = 23;
  localparam int RAMP_RST        = 350;
  localparam int THR_RST         = 2653;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIX_TARGET  = 2'd0,
    REG_RAMP_STEP   = 2'd1,
    REG_EQUAL_POWER = 2'd2,
    REG_DRY_THRESH  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RAMP,
    S_DRY,
    S_MIX,
    S_OUT
  } mix_state_e;

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_LOAD,
    D_ROOT
  } dry_state_e;

  // per-cycle control of a serial mix lane
  typedef struct packed {
    logic load;
    logic step;
    logic rnd;
    logic wet_bit;
    logic dry_bit;
  } lane_ctl_t;

endpackage

@@ rtl/swdm_dry.sv @@
// dry gain unit: linear complement, or serial multiply and bit-serial square root
module swdm_dry #(
  parameter int GAIN_FRAC_BITS = swdm_pkg::GAIN_FRAC_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    equal_power_i,
  input  logic [GAIN_FRAC_BITS:0] wet_gain_i,
  output logic                    done_o,
  output logic [GAIN_FRAC_BITS:0] dry_gain_o
);
  import swdm_pkg::*;

  localparam int GW   = GAIN_FRAC_BITS + 1;
  localparam int CNTW = $clog2(GW);
  localparam logic [GW-1:0]   ONE  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [CNTW-1:0] LAST = CNTW'(GW - 1);

  dry_state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q;
  logic            done_q;

  logic [GW:0]     a_q;
  logic [GW-1:0]   b_q;
  logic [GW:0]     mhi_q;
  logic [GW-1:0]   mlo_q;
  logic [2*GW-1:0] x_q;
  logic [GW:0]     rem_q;
  logic [GW-1:0]   root_q;
  logic [GW-1:0]   dry_q;

  logic [GW+1:0] msum;
  logic [GW+2:0] rem2;
  logic [GW+2:0] trial;
  logic          ge;
  logic [GW+2:0] rem_n;
  logic [GW-1:0] root_n;

  // (one - w) * (one + w) = one^2 - w^2, multiplier bits lsb first
  assign msum  = {1'b0, mhi_q} + (b_q[0] ? {1'b0, a_q} : '0);
  assign rem2  = {rem_q, x_q[2*GW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = (rem2 >= trial);
  assign rem_n = ge ? (rem2 - trial) : rem2;
  assign root_n = {root_q[GW-2:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      D_IDLE: begin
        if (start_i && equal_power_i) state_d = D_MUL;
      end
      D_MUL: begin
        if (cnt_q == LAST) state_d = D_LOAD;
      end
      D_LOAD: state_d = D_ROOT;
      D_ROOT: begin
        if (cnt_q == LAST) state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        D_IDLE: begin
          cnt_q <= '0;
          if (start_i && !equal_power_i) done_q <= 1'b1;
        end
        D_MUL: begin
          cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
        end
        D_LOAD: cnt_q <= '0;
        D_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST) done_q <= 1'b1;
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          dry_q <= ONE - wet_gain_i;
          a_q   <= {1'b0, ONE} + {1'b0, wet_gain_i};
          b_q   <= ONE - wet_gain_i;
          mhi_q <= '0;
          mlo_q <= '0;
        end
      end
      D_MUL: begin
        mhi_q <= msum[GW+1:1];
        mlo_q <= {msum[0], mlo_q[GW-1:1]};
        b_q   <= {1'b0, b_q[GW-1:1]};
      end
      D_LOAD: begin
        x_q    <= {mhi_q[GW-1:0], mlo_q};
        rem_q  <= '0;
        root_q <= '0;
      end
      D_ROOT: begin
        x_q    <= {x_q[2*GW-3:0], 2'b00};
        rem_q  <= rem_n[GW:0];
        root_q <= root_n;
        if (cnt_q == LAST) dry_q <= root_n;
      end
      default: ;
    endcase
  end

  assign done_o     = done_q;
  assign dry_gain_o = dry_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == D_IDLE)
    else $error("dry unit started while busy");

  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> dry_q <= ONE)
    else $error("dry gain above unity");

endmodule

@@ rtl/swdm_lane.sv @@
// one bit-serial mix lane: wet*wg + dry*dg with rounding and saturation
module swdm_lane #(
  parameter int SAMPLE_BITS = swdm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  swdm_pkg::lane_ctl_t           ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] wet_i,
  input  logic signed [SAMPLE_BITS-1:0] dry_i,
  output logic signed [SAMPLE_BITS-1:0] q_o
);
  import swdm_pkg::*;

  localparam int HW = SAMPLE_BITS + 2;
  localparam int SW = HW + 1;
  localparam int QW = HW + 1;
  localparam logic signed [QW-1:0] QMAX = {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {{(QW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [HW-1:0] hi_q;
  logic                 last_q;

  logic signed [SW-1:0] wet_x, dry_x, hi_x, sum;
  logic signed [QW-1:0] q;

  assign wet_x = {{3{wet_i[SAMPLE_BITS-1]}}, wet_i};
  assign dry_x = {{3{dry_i[SAMPLE_BITS-1]}}, dry_i};
  assign hi_x  = {hi_q[HW-1], hi_q};
  // accumulator lsb weighs 2^k at step k, so the half-lsb round is a carry-in
  assign sum   = hi_x + (ctl_i.wet_bit ? wet_x : '0) + (ctl_i.dry_bit ? dry_x : '0)
               + {{(SW-1){1'b0}}, ctl_i.rnd};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      hi_q   <= '0;
      last_q <= 1'b0;
    end else if (ctl_i.step) begin
      hi_q   <= sum[SW-1:1];
      last_q <= sum[0];
    end
  end

  // floor of the rounded sum over 2^frac
  assign q = {hi_q, last_q};

  always_comb begin
    if (q > QMAX) begin
      q_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (q < QMIN) begin
      q_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      q_o = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

@@ rtl/stereo_wet_dry_ramped_mixer_top.sv @@
// top level of the stereo wet/dry mixer with ramped wet gain
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+--------------------------------------
//  cfg     | in        | cfg_we_i                    | cfg_idx_i, cfg_wdata_i
//  in      | in        | in_valid_i / in_stall_o     | wet_left/right_i, dry_left/right_i
//  out     | out       | out_valid_o / out_stall_i   | out_left/right_o, is_dry_o, is_fading_o
//
// one frame at a time; each frame goes through the ramp, dry gain, mix and output
// states; in equal-power mode the dry gain state also waits out the serial multiply and root
// the mix is a bit-serial multiply over the gain bits; equal power adds a serial
// multiply and a two-bits-per-cycle square root in the dry gain unit
// reset gives full wet gain, no fade and the register defaults
// a finished frame waits in the output register; the next frame is taken meanwhile
module stereo_wet_dry_ramped_mixer_top #(
  parameter int SAMPLE_BITS    = swdm_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = swdm_pkg::GAIN_FRAC_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [swdm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [swdm_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]        wet_left_i,
  input  logic signed [SAMPLE_BITS-1:0]        wet_right_i,
  input  logic signed [SAMPLE_BITS-1:0]        dry_left_i,
  input  logic signed [SAMPLE_BITS-1:0]        dry_right_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        out_left_o,
  output logic signed [SAMPLE_BITS-1:0]        out_right_o,
  output logic                                 is_dry_o,
  output logic                                 is_fading_o
);
  import swdm_pkg::*;

  localparam int GW   = GAIN_FRAC_BITS + 1;
  localparam int CNTW = $clog2(GW);
  localparam int XW   = (GW > CFG_W) ? GW : CFG_W;
  localparam logic [GW-1:0]   ONE  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [CNTW-1:0] LAST = CNTW'(GW - 1);
  localparam logic [CNTW-1:0] RND  = CNTW'(GAIN_FRAC_BITS - 1);

  mix_state_e state_q, state_d;

  logic [GW-1:0]    mix_target_q;
  logic [GW-1:0]    ramp_q;
  logic             eqp_q;
  logic [CFG_W-1:0] thr_q;
  logic [GW-1:0]    wet_gain_q;
  logic             fading_q;

  logic [CNTW-1:0]  mcnt_q;
  logic [GW-1:0]    wg_sr_q;
  logic [GW-1:0]    dg_sr_q;

  logic signed [SAMPLE_BITS-1:0] wet_l_q, wet_r_q, dry_l_q, dry_r_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;
  logic                          is_dry_q, is_fading_q;

  logic          in_acc;
  logic          out_load;
  logic          dry_start;
  logic          dry_done;
  logic [GW-1:0] dry_gain;
  lane_ctl_t     lane_ctl;
  logic signed [SAMPLE_BITS-1:0] mix_l, mix_r;

  logic [GW-1:0] diff;
  logic [GW-1:0] ramp_gain;
  logic          ramp_fading;
  logic [XW-1:0] cfg_x, one_x, tgt_x, step_x;
  logic          dry_flag;

  // configuration saturation
  assign cfg_x  = XW'(cfg_wdata_i);
  assign one_x  = XW'(ONE);
  assign tgt_x  = (cfg_x > one_x) ? one_x : cfg_x;
  assign step_x = (cfg_x == '0) ? XW'(1) : ((cfg_x > one_x) ? one_x : cfg_x);

  // ramp or snap of the wet gain
  always_comb begin
    diff        = (wet_gain_q > mix_target_q) ? (wet_gain_q - mix_target_q)
                                              : (mix_target_q - wet_gain_q);
    ramp_gain   = wet_gain_q;
    ramp_fading = fading_q;
    if (fading_q) begin
      if (diff <= ramp_q) begin
        ramp_gain   = mix_target_q;
        ramp_fading = 1'b0;
      end else if (wet_gain_q < mix_target_q) begin
        ramp_gain = wet_gain_q + ramp_q;
      end else begin
        ramp_gain = wet_gain_q - ramp_q;
      end
    end
  end

  assign dry_flag = !fading_q && (XW'(mix_target_q) < XW'(thr_q));

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d          = state_q;
    dry_start        = 1'b0;
    out_load         = 1'b0;
    lane_ctl         = '0;
    lane_ctl.wet_bit = wg_sr_q[0];
    lane_ctl.dry_bit = dg_sr_q[0];
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_RAMP;
      end
      S_RAMP: begin
        dry_start = 1'b1;
        state_d   = S_DRY;
      end
      S_DRY: begin
        if (dry_done) begin
          lane_ctl.load = 1'b1;
          state_d       = S_MIX;
        end
      end
      S_MIX: begin
        lane_ctl.step = 1'b1;
        lane_ctl.rnd  = (mcnt_q == RND);
        if (mcnt_q == LAST) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_target_q <= ONE;
      ramp_q       <= GW'(RAMP_RST);
      eqp_q        <= 1'b0;
      thr_q        <= CFG_W'(THR_RST);
      wet_gain_q   <= ONE;
      fading_q     <= 1'b0;
      mcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == S_RAMP) begin
        wet_gain_q <= ramp_gain;
        fading_q   <= ramp_fading;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MIX_TARGET: begin
            if (tgt_x[GW-1:0] != mix_target_q) begin
              mix_target_q <= tgt_x[GW-1:0];
              fading_q     <= 1'b1;
            end
          end
          REG_RAMP_STEP:   ramp_q <= step_x[GW-1:0];
          REG_EQUAL_POWER: eqp_q  <= cfg_wdata_i[0];
          REG_DRY_THRESH:  thr_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (lane_ctl.load) begin
        mcnt_q <= '0;
      end else if (lane_ctl.step) begin
        mcnt_q <= mcnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wet_l_q <= wet_left_i;
      wet_r_q <= wet_right_i;
      dry_l_q <= dry_left_i;
      dry_r_q <= dry_right_i;
    end
    if (lane_ctl.load) begin
      wg_sr_q <= wet_gain_q;
      dg_sr_q <= dry_gain;
    end else if (lane_ctl.step) begin
      wg_sr_q <= {1'b0, wg_sr_q[GW-1:1]};
      dg_sr_q <= {1'b0, dg_sr_q[GW-1:1]};
    end
    if (out_load) begin
      out_l_q     <= mix_l;
      out_r_q     <= mix_r;
      is_dry_q    <= dry_flag;
      is_fading_q <= fading_q;
    end
  end

  swdm_dry #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dry (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (dry_start),
    .equal_power_i (eqp_q),
    .wet_gain_i    (ramp_gain),
    .done_o        (dry_done),
    .dry_gain_o    (dry_gain)
  );

  swdm_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_l (
    .clk_i (clk_i),
    .ctl_i (lane_ctl),
    .wet_i (wet_l_q),
    .dry_i (dry_l_q),
    .q_o   (mix_l)
  );

  swdm_lane #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_r (
    .clk_i (clk_i),
    .ctl_i (lane_ctl),
    .wet_i (wet_r_q),
    .dry_i (dry_r_q),
    .q_o   (mix_r)
  );

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign is_dry_o    = is_dry_q;
  assign is_fading_o = is_fading_q;

  a_settled_on_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fading_q |-> wet_gain_q == mix_target_q)
    else $error("wet gain off target while not fading");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wet_gain_q <= ONE && mix_target_q <= ONE)
    else $error("gain above unity");

  a_dry_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dry_done |-> state_q == S_DRY)
    else $error("dry gain finished outside its wait state");

endmodule
